/* sv/cssw_pkg.sv */
// ----------------------------------------------------------------------------
// cssw_pkg
// types and constants shared by the chip-select steering switch files
// ----------------------------------------------------------------------------
package cssw_pkg;

	// configuration register indexes
	localparam int unsigned CFG_COUNT = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT_TICKS = 2'd0,
		CFG_GREETING_BYTE = 2'd1,
		CFG_VERSION_BYTE  = 2'd2
	} cfg_index_t;

	// register reset values
	localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd125;
	localparam logic [7:0] GREETING_BYTE_RST = 8'hA5;
	localparam logic [7:0] VERSION_BYTE_RST  = 8'h02;

	// pattern reset value and timeout counter ceiling
	localparam logic [7:0] PATTERN_RST = 8'h0f;
	localparam logic [7:0] TIMEOUT_MAX = 8'hff;

	// result queue depth
	localparam int unsigned RES_DEPTH = 2;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_ARMED  = 2'd1,
		MODE_CONFIG = 2'd2
	} mode_t;

	typedef struct packed {
		logic [7:0] timeout_ticks;
		logic [7:0] greeting_byte;
		logic [7:0] version_byte;
	} cfg_t;

	typedef struct packed {
		logic chip_select;
		logic serial_clock;
		logic serial_in;
		logic tick;
	} sample_t;

	typedef struct packed {
		logic [7:0] port_a_drive;
		logic [1:0] port_b_drive;
		logic       serial_out;
		logic       configuring;
	} result_t;

endpackage

/* sv/cssw_stream_if.sv */
// ----------------------------------------------------------------------------
// cssw_stream_if
// valid/ready channel carrying one request payload of type T
// ----------------------------------------------------------------------------
interface cssw_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* sv/cssw_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cssw_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
module cssw_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cssw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cssw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output cssw_pkg::cfg_t                       cfg
);

	cssw_pkg::cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= cssw_pkg::TIMEOUT_TICKS_RST;
			cfg_q.greeting_byte <= cssw_pkg::GREETING_BYTE_RST;
			cfg_q.version_byte  <= cssw_pkg::VERSION_BYTE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				cssw_pkg::CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_wdata;
				cssw_pkg::CFG_GREETING_BYTE: cfg_q.greeting_byte <= cfg_wdata;
				cssw_pkg::CFG_VERSION_BYTE:  cfg_q.version_byte  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* sv/cssw_core.sv */
// ----------------------------------------------------------------------------
// cssw_core
// edge detection, mode control, spi slave shifter and port pattern state
// ----------------------------------------------------------------------------
module cssw_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  cssw_pkg::sample_t smp,
	input  cssw_pkg::cfg_t    cfg,
	output cssw_pkg::result_t res
);

	cssw_pkg::mode_t mode_q, mode_n;
	logic       prev_sel_q;
	logic       prev_clk_q;
	logic [7:0] shift_q, shift_n;
	logic [2:0] bit_cnt_q, bit_cnt_n;
	logic       byte_cnt_q, byte_cnt_n;
	logic [7:0] first_q, first_n;
	logic [7:0] tmo_q, tmo_n;
	logic [7:0] high_q, high_n;
	logic [7:0] low_q, low_n;
	logic [7:0] port_a_q, port_a_n;
	logic [1:0] port_b_q, port_b_n;

	logic       sel_edge;
	logic       clk_edge;
	logic [7:0] tmo_inc;
	logic [7:0] shift_in;

	// state registers, updated once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= cssw_pkg::MODE_IDLE;
			prev_sel_q <= 1'b1;
			prev_clk_q <= 1'b0;
			shift_q    <= '0;
			bit_cnt_q  <= '0;
			byte_cnt_q <= 1'b0;
			first_q    <= '0;
			tmo_q      <= '0;
			high_q     <= cssw_pkg::PATTERN_RST;
			low_q      <= cssw_pkg::PATTERN_RST;
			port_a_q   <= cssw_pkg::PATTERN_RST;
			port_b_q   <= '0;
		end else if (accept) begin
			mode_q     <= mode_n;
			prev_sel_q <= smp.chip_select;
			prev_clk_q <= smp.serial_clock;
			shift_q    <= shift_n;
			bit_cnt_q  <= bit_cnt_n;
			byte_cnt_q <= byte_cnt_n;
			first_q    <= first_n;
			tmo_q      <= tmo_n;
			high_q     <= high_n;
			low_q      <= low_n;
			port_a_q   <= port_a_n;
			port_b_q   <= port_b_n;
		end
	end

	// pin edges against the previous sample
	assign sel_edge = smp.chip_select != prev_sel_q;
	assign clk_edge = smp.serial_clock != prev_clk_q;
	assign tmo_inc  = (smp.tick && tmo_q != cssw_pkg::TIMEOUT_MAX) ? 8'(tmo_q + 8'd1) : tmo_q;
	assign shift_in = {shift_q[6:0], smp.serial_in};

	// next state
	always_comb begin
		mode_n     = mode_q;
		shift_n    = shift_q;
		bit_cnt_n  = bit_cnt_q;
		byte_cnt_n = byte_cnt_q;
		first_n    = first_q;
		tmo_n      = tmo_q;
		high_n     = high_q;
		low_n      = low_q;
		port_a_n   = port_a_q;
		port_b_n   = port_b_q;
		case (mode_q)
			cssw_pkg::MODE_CONFIG: begin
				tmo_n = tmo_inc;
				if (tmo_inc >= cfg.timeout_ticks) begin
					// exchange abandoned, patterns untouched
					mode_n = cssw_pkg::MODE_IDLE;
				end else if (clk_edge && smp.serial_clock) begin
					shift_n   = shift_in;
					bit_cnt_n = 3'(bit_cnt_q + 3'd1);
					if (bit_cnt_q == 3'd7) begin
						if (!byte_cnt_q) begin
							first_n    = shift_in;
							shift_n    = cfg.version_byte;
							byte_cnt_n = 1'b1;
						end else begin
							low_n      = shift_in;
							high_n     = first_q;
							port_a_n   = first_q;
							port_b_n   = first_q[5:4];
							byte_cnt_n = 1'b0;
							mode_n     = cssw_pkg::MODE_IDLE;
						end
					end
				end
			end
			cssw_pkg::MODE_IDLE, cssw_pkg::MODE_ARMED: begin
				if (sel_edge) begin
					port_a_n = smp.chip_select ? high_q : low_q;
					mode_n   = cssw_pkg::MODE_IDLE;
				end else if (smp.chip_select && clk_edge) begin
					if (smp.serial_clock) begin
						mode_n = cssw_pkg::MODE_ARMED;
					end else if (mode_q == cssw_pkg::MODE_ARMED) begin
						// rise then fall with select high: start exchange
						mode_n     = cssw_pkg::MODE_CONFIG;
						tmo_n      = '0;
						shift_n    = cfg.greeting_byte;
						bit_cnt_n  = '0;
						byte_cnt_n = 1'b0;
					end else begin
						mode_n = cssw_pkg::MODE_IDLE;
					end
				end
			end
			default: mode_n = cssw_pkg::MODE_IDLE;
		endcase
	end

	// result fields show the state after this sample
	always_comb begin
		res.port_a_drive = port_a_n;
		res.port_b_drive = port_b_n;
		res.configuring  = mode_n == cssw_pkg::MODE_CONFIG;
		res.serial_out   = (mode_n == cssw_pkg::MODE_CONFIG) ? shift_n[7] : 1'b0;
	end

endmodule

/* sv/cssw_res_buf.sv */
// ----------------------------------------------------------------------------
// cssw_res_buf
// small result queue between the core and the result channel
// ----------------------------------------------------------------------------
module cssw_res_buf #(
	parameter int unsigned DEPTH = cssw_pkg::RES_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cssw_pkg::result_t push_data,
	output logic              not_full,
	output logic              out_valid,
	input  logic              out_ready,
	output cssw_pkg::result_t out_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	cssw_pkg::result_t ent_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign not_full  = cnt_q != CNT_W'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_data  = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* sv/chip_select_steering_switch.sv */
// ----------------------------------------------------------------------------
// chip_select_steering_switch
// steers port A/B select pins from chip-select edges, configured over spi
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | per request
//  sample   | in  | chip_select, serial_clock, serial_in, tick       | one pin sample
//  result   | out | port_a_drive, port_b_drive, serial_out, config.  | one per sample
//  cfg_*    | in  | cfg_index, cfg_wdata under cfg_we                | one register
//
// one sample is taken per cycle while sample.ready is high; its result is registered in the result queue
// the state update and result logic sit between the sample handshake and a
// two-entry result queue, so samples keep flowing while one result waits
// sample.ready drops only when both queue entries hold untaken results
// reset is asynchronous, no clearing pass; the block is ready right after it
// ----------------------------------------------------------------------------
module chip_select_steering_switch #(
	parameter int unsigned RES_DEPTH = cssw_pkg::RES_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cssw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cssw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	cssw_stream_if.sink                     sample,
	cssw_stream_if.source                   result
);

	cssw_pkg::cfg_t    cfg;
	cssw_pkg::result_t core_res;
	logic              accept;
	logic              not_full;

	assign sample.ready = not_full;
	assign accept       = sample.valid && not_full;

	// configuration registers
	cssw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// per-sample logic and state
	cssw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.smp    (sample.payload),
		.cfg    (cfg),
		.res    (core_res)
	);

	// result queue
	cssw_res_buf #(
		.DEPTH (RES_DEPTH)
	) u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_res),
		.not_full  (not_full),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.payload)
	);

endmodule

/* sv/cssw_chk.sv */
// ----------------------------------------------------------------------------
// cssw_chk
// port-level checks for the chip-select steering switch
// ----------------------------------------------------------------------------
module cssw_chk (
	input logic              clk,
	input logic              arst_n,
	input logic              smp_valid,
	input logic              smp_ready,
	input logic              res_valid,
	input logic              res_ready,
	input cssw_pkg::result_t res_payload
);

	// miso stays low outside the exchange
	a_miso_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_payload.configuring |-> !res_payload.serial_out)
		else $error("serial_out high while not configuring");

	// a request taken into an empty queue shows a result next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready && !res_valid |=> res_valid)
		else $error("accepted sample produced no result");

	// samples stall only behind waiting results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!smp_ready |-> res_valid)
		else $error("sample stalled with no result pending");

	// a stalled result holds its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_payload))
		else $error("stalled result changed");

endmodule

bind chip_select_steering_switch cssw_chk u_cssw_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.smp_valid   (sample.valid),
	.smp_ready   (sample.ready),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_payload (result.payload)
);
